// ===== src/dtmr_pkg.sv =====
package dtmr_pkg;

    // Command codes carried by an input transaction
    typedef enum logic [1:0] {
        CMD_TICK  = 2'd0,
        CMD_STOP  = 2'd1,
        CMD_WRITE = 2'd2,
        CMD_READ  = 2'd3
    } t_cmd;

    // Register selects
    typedef enum logic [1:0] {
        SEL_DIV  = 2'd0,
        SEL_CNT  = 2'd1,
        SEL_MOD  = 2'd2,
        SEL_CTL  = 2'd3
    } t_sel;

    localparam int DIV_W  = 16;
    localparam int BYTE_W = 8;

    // Enable bit position inside the control register
    localparam int CTL_EN_BIT = 2;

    // Low divider bit of the divider read window (bits 13..6)
    localparam int DIV_RD_LSB = 6;

    // One input transaction as held in the input register
    typedef struct packed {
        logic [1:0]        command;
        logic [1:0]        reg_select;
        logic [BYTE_W-1:0] write_data;
    } t_item;

    // One result transaction
    typedef struct packed {
        logic [BYTE_W-1:0] read_data;
        logic              irq_pulse;
    } t_result;

    // Divider bit watched for each mode value
    function automatic logic [3:0] tap_index(input logic [1:0] mode);
        logic [3:0] idx;
        case (mode)
            2'd0:    idx = 4'd7;
            2'd1:    idx = 4'd1;
            2'd2:    idx = 4'd3;
            default: idx = 4'd5;
        endcase
        return idx;
    endfunction

endpackage

// ===== src/dtmr_if.sv =====
interface dtmr_in_if
    import dtmr_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [1:0]        command;
    logic [1:0]        reg_select;
    logic [BYTE_W-1:0] write_data;

    modport source (output valid, output command, output reg_select, output write_data,
                    input ready);
    modport sink   (input valid, input command, input reg_select, input write_data,
                    output ready);
endinterface

interface dtmr_out_if
    import dtmr_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] read_data;
    logic              irq_pulse;

    modport source (output valid, output read_data, output irq_pulse, input ready);
    modport sink   (input valid, input read_data, input irq_pulse, output ready);
endinterface

// ===== src/dtmr_in_reg.sv =====
module dtmr_in_reg
    import dtmr_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    dtmr_in_if.sink   i_in,
    input  logic      i_advance,
    output logic      o_valid,
    output t_item     o_item
);

    logic  r_valid;
    t_item r_item;

    // Take a new transaction when empty or when the held one moves on
    assign i_in.ready = !r_valid || i_advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_in.ready) begin
            r_valid <= i_in.valid;
        end
    end

    // Payload, no reset
    always_ff @(posedge i_clk) begin
        if (i_in.ready && i_in.valid) begin
            r_item.command    <= i_in.command;
            r_item.reg_select <= i_in.reg_select;
            r_item.write_data <= i_in.write_data;
        end
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;

endmodule

// ===== src/dtmr_core.sv =====
module dtmr_core
    import dtmr_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_advance,
    input  t_item   i_item,
    output t_result o_result
);

    logic [DIV_W-1:0]  r_divider,  n_divider;
    logic [BYTE_W-1:0] r_counter,  n_counter;
    logic [BYTE_W-1:0] r_modulo,   n_modulo;
    logic [BYTE_W-1:0] r_control,  n_control;
    logic              r_prev_tap, n_prev_tap;
    logic              r_irq_pending, n_irq_pending;
    logic              r_reload_flag, n_reload_flag;

    t_cmd cmd;
    t_sel sel;

    assign cmd = t_cmd'(i_item.command);
    assign sel = t_sel'(i_item.reg_select);

    // Next state and result for the held transaction
    always_comb begin
        logic              tap;
        logic              edge_hit;
        logic [BYTE_W-1:0] cnt_inc;

        n_divider     = r_divider;
        n_counter     = r_counter;
        n_modulo      = r_modulo;
        n_control     = r_control;
        n_prev_tap    = r_prev_tap;
        n_irq_pending = r_irq_pending;
        n_reload_flag = r_reload_flag;
        o_result      = '0;
        tap           = 1'b0;
        edge_hit      = 1'b0;
        cnt_inc       = '0;

        case (cmd)
            CMD_TICK: begin
                n_reload_flag = 1'b0;
                if (r_irq_pending) begin
                    n_irq_pending      = 1'b0;
                    o_result.irq_pulse = 1'b1;
                    n_counter          = r_modulo;
                    n_reload_flag      = 1'b1;
                end
                n_divider = r_divider + 1'b1;
                tap       = n_divider[tap_index(r_control[1:0])] & r_control[CTL_EN_BIT];
                edge_hit  = r_prev_tap && !tap;
                n_prev_tap = tap;
            end
            CMD_STOP: begin
                // Divider held at zero: tap is low
                n_divider  = '0;
                edge_hit   = r_prev_tap;
                n_prev_tap = 1'b0;
            end
            CMD_WRITE: begin
                case (sel)
                    SEL_DIV: begin
                        n_divider  = '0;
                        edge_hit   = r_prev_tap;
                        n_prev_tap = 1'b0;
                    end
                    SEL_CNT: begin
                        if (!r_reload_flag) begin
                            n_counter = i_item.write_data;
                        end
                        n_irq_pending = 1'b0;
                    end
                    SEL_MOD: begin
                        if (r_reload_flag) begin
                            n_counter = i_item.write_data;
                        end
                        n_modulo = i_item.write_data;
                    end
                    default: begin
                        tap        = r_prev_tap & i_item.write_data[CTL_EN_BIT];
                        edge_hit   = r_prev_tap && !tap;
                        n_prev_tap = tap;
                        n_control  = i_item.write_data;
                    end
                endcase
            end
            default: begin
                case (sel)
                    SEL_DIV: o_result.read_data = r_divider[DIV_RD_LSB +: BYTE_W];
                    SEL_CNT: o_result.read_data = r_counter;
                    SEL_MOD: o_result.read_data = r_modulo;
                    default: o_result.read_data = r_control;
                endcase
            end
        endcase

        // Falling tap edge bumps the counter; wrap arms the interrupt
        if (edge_hit) begin
            cnt_inc   = n_counter + 1'b1;
            n_counter = cnt_inc;
            if (cnt_inc == '0) begin
                n_irq_pending = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_divider     <= '0;
            r_counter     <= '0;
            r_modulo      <= '0;
            r_control     <= '0;
            r_prev_tap    <= 1'b0;
            r_irq_pending <= 1'b0;
            r_reload_flag <= 1'b0;
        end else if (i_advance) begin
            r_divider     <= n_divider;
            r_counter     <= n_counter;
            r_modulo      <= n_modulo;
            r_control     <= n_control;
            r_prev_tap    <= n_prev_tap;
            r_irq_pending <= n_irq_pending;
            r_reload_flag <= n_reload_flag;
        end
    end

`ifndef ASSERT_OFF
    // A raised interrupt always opens a reload cycle with the modulo loaded
    a_irq_reload: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_advance && o_result.irq_pulse |=> r_reload_flag)
        else $error("interrupt without reload cycle");

    // Only ticks raise the interrupt
    a_irq_tick: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result.irq_pulse |-> (cmd == CMD_TICK) && r_irq_pending)
        else $error("interrupt on a non-tick transaction");

    // Divider write or stopped tick clears the divider
    a_div_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_advance && ((cmd == CMD_STOP) || ((cmd == CMD_WRITE) && (sel == SEL_DIV)))
        |=> (r_divider == '0) && !r_prev_tap)
        else $error("divider not cleared");

    // Reads leave the state alone
    a_read_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_advance && (cmd == CMD_READ)
        |=> $stable(r_divider) && $stable(r_counter) && $stable(r_irq_pending))
        else $error("read changed state");
`endif

endmodule

// ===== src/dtmr_out_reg.sv =====
module dtmr_out_reg
    import dtmr_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_load,
    input  t_result   i_result,
    output logic      o_can_load,
    dtmr_out_if.source o_out
);

    logic    r_valid;
    t_result r_result;

    // Room when empty or the held result is taken this cycle
    assign o_can_load = !r_valid || o_out.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_can_load) begin
            r_valid <= i_load;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load && o_can_load) begin
            r_result <= i_result;
        end
    end

    assign o_out.valid     = r_valid;
    assign o_out.read_data = r_result.read_data;
    assign o_out.irq_pulse = r_result.irq_pulse;

endmodule

// ===== src/divider_timer_modulo_reload.sv =====
// Channel  Dir  Handshake      Payload
// i_in     in   valid/ready    command[1:0], reg_select[1:0], write_data[7:0]
// o_out    out  valid/ready    read_data[7:0], irq_pulse
//
// One transaction per clock sustained while the output is not stalled; an accepted item
// passes through the input register and then the result register before it can be taken.
// All timer state updates at the same edge as the held item moves to the result register.
// Synchronous active-low reset clears the timer state and both valid flags, not the payloads.
// A stalled output holds its result; the input register still takes one more item.
module divider_timer_modulo_reload
    import dtmr_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    dtmr_in_if.sink    i_in,
    dtmr_out_if.source o_out
);

    logic    in_valid;
    t_item   item;
    logic    can_load;
    logic    advance;
    t_result result;

    // Held item moves on when the result register has room
    assign advance = in_valid && can_load;

    dtmr_in_reg u_in_reg (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_in      (i_in),
        .i_advance (advance),
        .o_valid   (in_valid),
        .o_item    (item)
    );

    dtmr_core u_core (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_advance (advance),
        .i_item    (item),
        .o_result  (result)
    );

    dtmr_out_reg u_out_reg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_load     (advance),
        .i_result   (result),
        .o_can_load (can_load),
        .o_out      (o_out)
    );

endmodule

// ===== sim/tb_divider_timer_modulo_reload.sv =====
module tb_divider_timer_modulo_reload;
    import dtmr_pkg::*;

    // Mode field of the control register: which divider bit clocks the counter
    localparam logic [1:0] MODE_BIT7 = 2'd0;
    localparam logic [1:0] MODE_BIT1 = 2'd1;
    localparam logic [1:0] MODE_BIT3 = 2'd2;
    localparam logic [1:0] MODE_BIT5 = 2'd3;

    localparam int RANDOM_ITEMS   = 450;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int HOLD_CYCLES    = 60;
    localparam int MAX_REPORTS    = 10;

    // Timer state tracker and result checker
    class timer_checker;
        logic [DIV_W-1:0]  divider;
        logic [BYTE_W-1:0] counter;
        logic [BYTE_W-1:0] modulo;
        logic [BYTE_W-1:0] control;
        logic              prev_tap;
        logic              irq_pending;
        logic              reload_flag;
        t_result           due_results[$];
        int                errors;

        function new();
            divider     = '0;
            counter     = '0;
            modulo      = '0;
            control     = '0;
            prev_tap    = 1'b0;
            irq_pending = 1'b0;
            reload_flag = 1'b0;
            errors      = 0;
        endfunction

        // Falling edge on the gated tap bumps the counter; wrap arms the irq
        function void count_edge(logic was, logic now);
            if (was && !now) begin
                counter = counter + 8'd1;
                if (counter == '0)
                    irq_pending = 1'b1;
            end
        endfunction

        function void move_divider(logic [DIV_W-1:0] value);
            logic tap;
            divider = value;
            case (control[1:0])
                MODE_BIT7: tap = divider[7];
                MODE_BIT1: tap = divider[1];
                MODE_BIT3: tap = divider[3];
                default:   tap = divider[5];
            endcase
            tap = tap & control[CTL_EN_BIT];
            count_edge(prev_tap, tap);
            prev_tap = tap;
        endfunction

        // Advance the timer by one accepted transaction
        function t_result step_timer(t_item it);
            t_result res;
            logic    old_tap;
            res = '0;
            case (it.command)
                CMD_TICK: begin
                    reload_flag = 1'b0;
                    if (irq_pending) begin
                        irq_pending   = 1'b0;
                        res.irq_pulse = 1'b1;
                        counter       = modulo;
                        reload_flag   = 1'b1;
                    end
                    move_divider(divider + 16'd1);
                end
                CMD_STOP: move_divider('0);
                CMD_WRITE: begin
                    case (it.reg_select)
                        SEL_DIV: move_divider('0);
                        SEL_CNT: begin
                            if (!reload_flag)
                                counter = it.write_data;
                            irq_pending = 1'b0;
                        end
                        SEL_MOD: begin
                            if (reload_flag)
                                counter = it.write_data;
                            modulo = it.write_data;
                        end
                        default: begin
                            old_tap  = prev_tap;
                            prev_tap = prev_tap & it.write_data[CTL_EN_BIT];
                            count_edge(old_tap, prev_tap);
                            control  = it.write_data;
                        end
                    endcase
                end
                default: begin
                    case (it.reg_select)
                        SEL_DIV: res.read_data = divider[DIV_RD_LSB +: BYTE_W];
                        SEL_CNT: res.read_data = counter;
                        SEL_MOD: res.read_data = modulo;
                        default: res.read_data = control;
                    endcase
                end
            endcase
            return res;
        endfunction

        function void note_item(t_item it);
            due_results.push_back(step_timer(it));
        endfunction

        function void check_result(logic [BYTE_W-1:0] rd, logic irq);
            t_result exp;
            if (due_results.size() == 0) begin
                errors++;
                if (errors <= MAX_REPORTS)
                    $display("unexpected result: read_data=%02h irq_pulse=%0b", rd, irq);
            end else begin
                exp = due_results.pop_front();
                if (exp.read_data !== rd || exp.irq_pulse !== irq) begin
                    errors++;
                    if (errors <= MAX_REPORTS)
                        $display("mismatch: read_data exp %02h got %02h, irq_pulse exp %0b got %0b",
                                 exp.read_data, rd, exp.irq_pulse, irq);
                end
            end
        endfunction

        function int outstanding();
            return due_results.size();
        endfunction
    endclass

    logic i_clk;
    logic i_rst_n;

    dtmr_in_if  in_if();
    dtmr_out_if out_if();

    divider_timer_modulo_reload u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if)
    );

    timer_checker chk;
    bit           idle_on;
    bit           hold_req;
    int           items_sent;
    int           quiet_cycles;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Offer one transaction, with random idle cycles ahead of it
    task automatic send_item(t_cmd cmd, t_sel sel, logic [BYTE_W-1:0] data);
        t_item it;
        while (idle_on && $urandom_range(0, 99) < 36) begin
            in_if.valid <= 1'b0;
            @(posedge i_clk);
        end
        it.command    = cmd;
        it.reg_select = sel;
        it.write_data = data;
        in_if.valid      <= 1'b1;
        in_if.command    <= it.command;
        in_if.reg_select <= it.reg_select;
        in_if.write_data <= it.write_data;
        @(posedge i_clk);
        while (!in_if.ready)
            @(posedge i_clk);
        chk.note_item(it);
        items_sent++;
    endtask

    // Any transaction: mostly ticks, then writes, reads and stopped ticks
    task automatic send_noise();
        int   pick;
        t_cmd cmd;
        pick = $urandom_range(0, 99);
        if (pick < 50)
            cmd = CMD_TICK;
        else if (pick < 58)
            cmd = CMD_STOP;
        else if (pick < 82)
            cmd = CMD_WRITE;
        else
            cmd = CMD_READ;
        send_item(cmd, t_sel'($urandom_range(0, 3)), 8'($urandom));
    endtask

    task automatic tick_until_pending();
        int guard;
        guard = 0;
        while (!chk.irq_pending && guard < 80) begin
            send_item(CMD_TICK, t_sel'($urandom_range(0, 3)), 8'($urandom));
            guard++;
        end
    endtask

    task automatic wait_drained();
        in_if.valid <= 1'b0;
        while (chk.outstanding() != 0)
            @(posedge i_clk);
    endtask

    // Result side: check, then pick ready for the next cycle
    initial begin : result_sink
        int hold_left;
        hold_left = 0;
        out_if.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && out_if.valid && out_if.ready)
                chk.check_result(out_if.read_data, out_if.irq_pulse);
            if (hold_req && hold_left == 0) begin
                hold_left = HOLD_CYCLES;
                hold_req  = 1'b0;
            end
            if (hold_left > 0) begin
                hold_left--;
                out_if.ready <= 1'b0;
            end else begin
                out_if.ready <= !(idle_on && $urandom_range(0, 99) < 36);
            end
        end
    end

    // Watchdog: too long with no transaction on either side
    always @(posedge i_clk) begin
        if (!i_rst_n || (in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("tb_divider_timer_modulo_reload: errors");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin : stimulus
        logic [1:0] mode;
        logic [7:0] ctl;
        logic [7:0] cnt0;
        bit         hold_done;
        bit         pause_done;
        chk          = new();
        idle_on      = 1'b1;
        hold_req     = 1'b0;
        items_sent   = 0;
        quiet_cycles = 0;
        hold_done    = 1'b0;
        pause_done   = 1'b0;
        i_rst_n          <= 1'b0;
        in_if.valid      <= 1'b0;
        in_if.command    <= CMD_TICK;
        in_if.reg_select <= SEL_DIV;
        in_if.write_data <= '0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: reset values, all-ones control, overflow and reload quirks
        send_item(CMD_READ, SEL_DIV, 8'hFF);
        send_item(CMD_READ, SEL_CNT, 8'h00);
        send_item(CMD_READ, SEL_MOD, 8'hFF);
        send_item(CMD_READ, SEL_CTL, 8'h00);
        send_item(CMD_WRITE, SEL_CTL, 8'hFF);
        send_item(CMD_READ, SEL_CTL, 8'h00);
        send_item(CMD_WRITE, SEL_CTL, {5'b0, 1'b1, MODE_BIT1});
        send_item(CMD_WRITE, SEL_MOD, 8'hA5);
        send_item(CMD_WRITE, SEL_CNT, 8'hFF);
        tick_until_pending();
        // tick raising the irq; modulo write in the reload cycle lands in the counter
        send_item(CMD_TICK, SEL_DIV, 8'h00);
        send_item(CMD_WRITE, SEL_MOD, 8'h5A);
        send_item(CMD_WRITE, SEL_CNT, 8'h00);
        send_item(CMD_READ, SEL_CNT, 8'h00);
        // counter write while the irq is pending cancels it
        send_item(CMD_WRITE, SEL_CNT, 8'hFF);
        tick_until_pending();
        send_item(CMD_WRITE, SEL_CNT, 8'h77);
        send_item(CMD_TICK, SEL_DIV, 8'h00);
        send_item(CMD_READ, SEL_CNT, 8'h00);
        // spurious edges: divider clear, stopped tick, enable dropped
        send_item(CMD_TICK, SEL_DIV, 8'h00);
        send_item(CMD_WRITE, SEL_DIV, 8'hFF);
        send_item(CMD_TICK, SEL_DIV, 8'h00);
        send_item(CMD_STOP, SEL_DIV, 8'h00);
        send_item(CMD_WRITE, SEL_CTL, 8'h00);
        send_item(CMD_READ, SEL_DIV, 8'h00);

        // Random: overflow sequences with random content, plus noise
        items_sent = 0;
        while (items_sent < RANDOM_ITEMS) begin
            if (!hold_done && items_sent > 150) begin
                hold_done = 1'b1;
                hold_req  = 1'b1;
            end
            if (!pause_done && items_sent > 300) begin
                pause_done = 1'b1;
                wait_drained();
            end
            idle_on = !(items_sent > 200 && items_sent < 320);

            if ($urandom_range(0, 99) < 35) begin
                mode = ($urandom_range(0, 19) == 0) ? MODE_BIT7
                                                    : 2'($urandom_range(1, 3));
                ctl  = {5'($urandom), 1'b1, mode};
                // start close enough to the wrap that a short run of ticks reaches it
                case (mode)
                    MODE_BIT1: cnt0 = 8'($urandom_range(8'hF8, 8'hFF));
                    MODE_BIT3: cnt0 = 8'($urandom_range(8'hFC, 8'hFF));
                    default:   cnt0 = 8'hFF;
                endcase
                send_item(CMD_WRITE, SEL_CTL, ctl);
                send_item(CMD_WRITE, SEL_MOD, 8'($urandom));
                send_item(CMD_WRITE, SEL_CNT, cnt0);
                tick_until_pending();
                // one random transaction while the irq is pending, another after the tick that follows it
                send_noise();
                send_item(CMD_TICK, SEL_DIV, 8'($urandom));
                send_noise();
                send_item(CMD_READ, SEL_CNT, 8'($urandom));
            end else begin
                send_noise();
            end
        end
        in_if.valid <= 1'b0;

        wait_drained();
        repeat (4) @(posedge i_clk);
        if (chk.errors == 0 && chk.outstanding() == 0)
            $display("tb_divider_timer_modulo_reload: clean");
        else
            $display("tb_divider_timer_modulo_reload: errors");
        $finish;
    end

endmodule

// ===== sim.f =====
src/dtmr_pkg.sv
src/dtmr_if.sv
src/dtmr_in_reg.sv
src/dtmr_core.sv
src/dtmr_out_reg.sv
src/divider_timer_modulo_reload.sv
sim/tb_divider_timer_modulo_reload.sv
